// ===== hdl/qgbh_pkg.sv =====
// Shared types and constants for the quantized grid with bounded cell history.
// Used by the top level, the multiply-add unit and the port checker.
package qgbh_pkg;

  localparam int COORD_W    = 16;
  localparam int DATA_W     = 32;
  localparam int CELL_OUT_W = 6;
  localparam int ENTRY_W    = 3 * COORD_W + DATA_W;
  localparam int SIDE_REG_W = 3;
  localparam int CAP_REG_W  = 4;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_GRID_SIDE     = 1'b0,
    REG_CELL_CAPACITY = 1'b1
  } reg_idx_t;

  localparam logic [SIDE_REG_W-1:0] GRID_SIDE_RESET     = 3'd4;
  localparam logic [CAP_REG_W-1:0]  CELL_CAPACITY_RESET = 4'd8;

endpackage

// ===== hdl/quantized_grid_bounded_history.sv =====
// Top level of the quantized grid with a bounded per-cell history.
// Depends on qgbh_pkg and the shared multiply-add unit qgbh_mac.
//
// A push quantizes its three coordinates and folds them into a cell index on
// one shared multiply-add unit, five passes in a row, then does a
// read-modify-write of that cell's ring pointer and fill count and stores the
// entry; the pointer and count come from a registered memory read. A read
// fetches the cell's pointer and count from the registered pointer memory and
// then gives one result per stored entry, each entry coming from the registered
// entry memory; an empty cell gives one result. The block takes one request at
// a time. After reset a clearing pass zeroes the per-cell pointers and counts
// of all MAX_SIDE^3 cells (64 at the defaults), during which no request is
// taken; register writes are taken throughout.
module quantized_grid_bounded_history #(
  parameter int MAX_SIDE     = 4,
  parameter int MAX_CAPACITY = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 command,
  input  logic [qgbh_pkg::COORD_W-1:0]         coord_first,
  input  logic [qgbh_pkg::COORD_W-1:0]         coord_second,
  input  logic [qgbh_pkg::COORD_W-1:0]         coord_third,
  input  logic [qgbh_pkg::DATA_W-1:0]          entry_data,
  input  logic [qgbh_pkg::CELL_OUT_W-1:0]      read_cell,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [qgbh_pkg::CELL_OUT_W-1:0]      cell_index,
  output logic                                 evicted,
  output logic [qgbh_pkg::COORD_W-1:0]         out_first,
  output logic [qgbh_pkg::COORD_W-1:0]         out_second,
  output logic [qgbh_pkg::COORD_W-1:0]         out_third,
  output logic [qgbh_pkg::DATA_W-1:0]          out_data,
  output logic                                 cell_empty,
  output logic                                 last,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [qgbh_pkg::PADDR_W-1:0]         paddr,
  input  logic [qgbh_pkg::PDATA_W-1:0]         pwdata,
  output logic [qgbh_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready
);

  localparam int NUM_CELLS = MAX_SIDE * MAX_SIDE * MAX_SIDE;
  localparam int NUM_SLOTS = NUM_CELLS * MAX_CAPACITY;
  localparam int S_W       = $clog2(MAX_SIDE + 1);
  localparam int CAP_W     = $clog2(MAX_CAPACITY + 1);
  localparam int SUM_W     = CAP_W + 1;
  localparam int SLOT_W    = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
  localparam int CELL_W    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int ADDR_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int META_W    = SLOT_W + CAP_W;
  localparam int COORD_W   = qgbh_pkg::COORD_W;
  localparam int ENTRY_W   = qgbh_pkg::ENTRY_W;
  localparam int DATA_W    = qgbh_pkg::DATA_W;
  localparam int P_W       = COORD_W + S_W;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QA,
    ST_QB,
    ST_HB,
    ST_QC,
    ST_HC,
    ST_P_WAIT,
    ST_P_USE,
    ST_P_EMIT,
    ST_R_WAIT_META,
    ST_R_META,
    ST_R_WAIT,
    ST_R_EMIT,
    ST_R_EMPTY
  } state_t;

  state_t state;

  logic [qgbh_pkg::SIDE_REG_W-1:0] grid_side;
  logic [qgbh_pkg::CAP_REG_W-1:0]  cell_capacity;

  logic [COORD_W-1:0]    req_first;
  logic [COORD_W-1:0]    req_second;
  logic [COORD_W-1:0]    req_third;
  logic [DATA_W-1:0]     req_data;
  logic [qgbh_pkg::CELL_OUT_W-1:0] req_cell_out;
  logic                  req_oob;
  logic [CELL_W-1:0]     acc;
  logic [S_W-1:0]        q_hold;
  logic                  evict;
  logic [CELL_W-1:0]     clr_idx;
  logic [CAP_W-1:0]      rd_n;
  logic [CAP_W-1:0]      rd_k;
  logic [SLOT_W-1:0]     rd_slot;

  logic [META_W-1:0]     meta_mem [NUM_CELLS];
  logic [CELL_W-1:0]     meta_raddr;
  logic [META_W-1:0]     meta_q;
  logic                  meta_we;
  logic [CELL_W-1:0]     meta_waddr;
  logic [META_W-1:0]     meta_wdata;

  logic [ENTRY_W-1:0]    ent_mem [NUM_SLOTS];
  logic [ADDR_W-1:0]     ent_raddr;
  logic [ENTRY_W-1:0]    ent_q;
  logic                  ent_we;
  logic [ADDR_W-1:0]     ent_waddr;

  logic [S_W-1:0]        side_eff;
  logic [CAP_W-1:0]      cap_eff;
  logic [COORD_W-1:0]    mac_x;
  logic [S_W-1:0]        mac_add;
  logic [P_W-1:0]        mac_sum;
  logic [S_W-1:0]        quant;

  logic [CAP_W-1:0]      meta_fill;
  logic [SLOT_W-1:0]     meta_old;
  logic                  over_cap;
  logic [SLOT_W-1:0]     new_old;
  logic [CAP_W-1:0]      new_fill;
  logic [SLOT_W-1:0]     put_slot;
  logic [SLOT_W-1:0]     next_slot;
  logic                  out_free;
  logic                  emit;
  logic                  cfg_write;

  function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SUM_W-1:0] v);
    logic [SUM_W-1:0] r;
    r = (v >= SUM_W'(MAX_CAPACITY)) ? v - SUM_W'(MAX_CAPACITY) : v;
    return SLOT_W'(r);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [CELL_W-1:0] c,
                                                  input logic [SLOT_W-1:0] s);
    return ADDR_W'(ADDR_W'(c) * ADDR_W'(MAX_CAPACITY) + ADDR_W'(s));
  endfunction

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (qgbh_pkg::reg_idx_t'(paddr[2]))
      qgbh_pkg::REG_GRID_SIDE:     prdata = qgbh_pkg::PDATA_W'(grid_side);
      qgbh_pkg::REG_CELL_CAPACITY: prdata = qgbh_pkg::PDATA_W'(cell_capacity);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side     <= qgbh_pkg::GRID_SIDE_RESET;
      cell_capacity <= qgbh_pkg::CELL_CAPACITY_RESET;
    end else if (cfg_write) begin
      case (qgbh_pkg::reg_idx_t'(paddr[2]))
        qgbh_pkg::REG_GRID_SIDE:     grid_side     <= pwdata[qgbh_pkg::SIDE_REG_W-1:0];
        qgbh_pkg::REG_CELL_CAPACITY: cell_capacity <= pwdata[qgbh_pkg::CAP_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp registers to their usable range
  always_comb begin
    if (grid_side == '0) begin
      side_eff = S_W'(1);
    end else if (int'(grid_side) > MAX_SIDE) begin
      side_eff = S_W'(MAX_SIDE);
    end else begin
      side_eff = S_W'(grid_side);
    end
    if (cell_capacity == '0) begin
      cap_eff = CAP_W'(1);
    end else if (int'(cell_capacity) > MAX_CAPACITY) begin
      cap_eff = CAP_W'(MAX_CAPACITY);
    end else begin
      cap_eff = CAP_W'(cell_capacity);
    end
  end

  // shared multiply-add operand select
  always_comb begin
    case (state)
      ST_QA:   begin mac_x = req_first;       mac_add = '0;     end
      ST_QB:   begin mac_x = req_second;      mac_add = '0;     end
      ST_QC:   begin mac_x = req_third;       mac_add = '0;     end
      ST_HB,
      ST_HC:   begin mac_x = COORD_W'(acc);   mac_add = q_hold; end
      default: begin mac_x = req_first;       mac_add = '0;     end
    endcase
  end

  qgbh_mac #(.M_W(S_W)) u_mac (
    .x      (mac_x),
    .m      (side_eff),
    .addend (mac_add),
    .sum    (mac_sum)
  );

  always_comb begin
    quant = mac_sum[COORD_W +: S_W];
    if (quant > side_eff - S_W'(1)) begin
      quant = side_eff - S_W'(1);
    end
  end

  // ring pointer update for a push
  always_comb begin
    meta_fill = meta_q[CAP_W-1:0];
    meta_old  = meta_q[CAP_W +: SLOT_W];
    over_cap  = (meta_fill >= cap_eff);
    if (over_cap) begin
      new_old  = wrap_slot(SUM_W'(meta_old) + SUM_W'(meta_fill) - SUM_W'(cap_eff)
                           + SUM_W'(1));
      new_fill = cap_eff - CAP_W'(1);
    end else begin
      new_old  = meta_old;
      new_fill = meta_fill;
    end
    put_slot  = wrap_slot(SUM_W'(new_old) + SUM_W'(new_fill));
    next_slot = wrap_slot(SUM_W'(rd_slot) + SUM_W'(1));
  end

  // memory write port controls
  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = acc;
    meta_wdata = {new_old, new_fill + CAP_W'(1)};
    ent_we     = 1'b0;
    ent_waddr  = slot_addr(acc, put_slot);
    case (state)
      ST_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_idx;
        meta_wdata = '0;
      end
      ST_P_USE: begin
        meta_we = 1'b1;
        ent_we  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    meta_q <= meta_mem[meta_raddr];
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= {req_first, req_second, req_third, req_data};
    end
    ent_q <= ent_mem[ent_raddr];
  end

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign emit     = out_free && (state == ST_P_EMIT || state == ST_R_EMIT ||
                                 state == ST_R_EMPTY);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + CELL_W'(1);
          if (int'(clr_idx) == NUM_CELLS - 1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            req_first    <= coord_first;
            req_second   <= coord_second;
            req_third    <= coord_third;
            req_data     <= entry_data;
            req_cell_out <= read_cell;
            req_oob      <= (int'(read_cell) >= NUM_CELLS);
            acc          <= CELL_W'(read_cell);
            meta_raddr   <= CELL_W'(read_cell);
            if (qgbh_pkg::cmd_t'(command) == qgbh_pkg::CMD_READ) begin
              state <= ST_R_WAIT_META;
            end else begin
              state <= ST_QA;
            end
          end
        end
        ST_QA: begin
          acc   <= CELL_W'(quant);
          state <= ST_QB;
        end
        ST_QB: begin
          q_hold <= quant;
          state  <= ST_HB;
        end
        ST_HB: begin
          acc   <= CELL_W'(mac_sum);
          state <= ST_QC;
        end
        ST_QC: begin
          q_hold <= quant;
          state  <= ST_HC;
        end
        ST_HC: begin
          acc          <= CELL_W'(mac_sum);
          meta_raddr   <= CELL_W'(mac_sum);
          req_cell_out <= qgbh_pkg::CELL_OUT_W'(mac_sum);
          state        <= ST_P_WAIT;
        end
        ST_P_WAIT: begin
          state <= ST_P_USE;
        end
        ST_P_USE: begin
          evict <= over_cap;
          state <= ST_P_EMIT;
        end
        ST_P_EMIT: begin
          if (out_free) begin
            cell_index <= req_cell_out;
            evicted    <= evict;
            out_first  <= '0;
            out_second <= '0;
            out_third  <= '0;
            out_data   <= '0;
            cell_empty <= 1'b0;
            last       <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        ST_R_WAIT_META: begin
          state <= ST_R_META;
        end
        ST_R_META: begin
          rd_n      <= req_oob ? '0 : meta_fill;
          rd_k      <= '0;
          rd_slot   <= meta_old;
          ent_raddr <= slot_addr(acc, meta_old);
          if (req_oob || meta_fill == '0) begin
            state <= ST_R_EMPTY;
          end else begin
            state <= ST_R_WAIT;
          end
        end
        ST_R_WAIT: begin
          state <= ST_R_EMIT;
        end
        ST_R_EMIT: begin
          if (out_free) begin
            cell_index <= req_cell_out;
            evicted    <= 1'b0;
            out_first  <= ent_q[DATA_W + 2*COORD_W +: COORD_W];
            out_second <= ent_q[DATA_W + COORD_W +: COORD_W];
            out_third  <= ent_q[DATA_W +: COORD_W];
            out_data   <= ent_q[DATA_W-1:0];
            cell_empty <= 1'b0;
            last       <= (rd_k + CAP_W'(1) == rd_n);
            if (rd_k + CAP_W'(1) == rd_n) begin
              state <= ST_IDLE;
            end else begin
              rd_k      <= rd_k + CAP_W'(1);
              rd_slot   <= next_slot;
              ent_raddr <= slot_addr(acc, next_slot);
              state     <= ST_R_WAIT;
            end
          end
        end
        ST_R_EMPTY: begin
          if (out_free) begin
            cell_index <= req_cell_out;
            evicted    <= 1'b0;
            out_first  <= '0;
            out_second <= '0;
            out_third  <= '0;
            out_data   <= '0;
            cell_empty <= 1'b1;
            last       <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/qgbh_mac.sv =====
// Shared multiply-add unit: x * m + addend, one product per cycle.
// Serves both coordinate quantizing and cell index accumulation; uses qgbh_pkg.
module qgbh_mac #(
  parameter int M_W = 3
) (
  input  logic [qgbh_pkg::COORD_W-1:0]     x,
  input  logic [M_W-1:0]                   m,
  input  logic [M_W-1:0]                   addend,
  output logic [qgbh_pkg::COORD_W+M_W-1:0] sum
);

  localparam int P_W = qgbh_pkg::COORD_W + M_W;

  assign sum = P_W'(x) * P_W'(m) + P_W'(addend);

endmodule

// ===== hdl/qgbh_check.sv =====
// Port-level checker for quantized_grid_bounded_history, bound to the top level.
// Watches request and result channels only; uses qgbh_pkg for field widths.
module qgbh_check (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [qgbh_pkg::CELL_OUT_W-1:0] cell_index,
  input logic                            evicted,
  input logic [qgbh_pkg::COORD_W-1:0]    out_first,
  input logic [qgbh_pkg::COORD_W-1:0]    out_second,
  input logic [qgbh_pkg::COORD_W-1:0]    out_third,
  input logic [qgbh_pkg::DATA_W-1:0]     out_data,
  input logic                            cell_empty,
  input logic                            last
);

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("request taken during clearing pass");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in work");

  a_evict_is_push: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted |-> last && !cell_empty)
    else $error("eviction flag on a read result");

  a_empty_is_blank: assert property (@(posedge clk) disable iff (rst)
    out_valid && cell_empty |-> last && !evicted && out_first == '0 &&
      out_second == '0 && out_third == '0 && out_data == '0)
    else $error("empty result carries entry fields");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cell_index) && $stable(last))
    else $error("stalled result changed");

endmodule

bind quantized_grid_bounded_history qgbh_check u_qgbh_check (.*);
